// ===== hdl/ppmfd_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the
// PPM frame decoder. No dependencies.
`default_nettype none

package ppmfd_pkg;

  localparam int unsigned CHANNEL_SLOTS_DEF = 8;

  // Item operations
  localparam logic [1:0] OP_EDGE     = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_READ_ONE = 2'd2;
  localparam logic [1:0] OP_READ_ALL = 2'd3;

  // Edge status codes
  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_PUBLISHED = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_BAD_WIDTH = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_SYNC_GAP     = 3'd1;
  localparam logic [2:0] REG_PULSE_MIN    = 3'd2;
  localparam logic [2:0] REG_PULSE_MAX    = 3'd3;
  localparam logic [2:0] REG_MIN_CHANNELS = 3'd4;
  localparam logic [2:0] REG_TIMEOUT      = 3'd5;

  // Register reset values
  localparam logic [15:0] SYNC_GAP_RST     = 16'd3000;
  localparam logic [15:0] PULSE_MIN_RST    = 16'd900;
  localparam logic [15:0] PULSE_MAX_RST    = 16'd2100;
  localparam logic [4:0]  MIN_CHANNELS_RST = 5'd4;
  localparam logic [15:0] TIMEOUT_RST      = 16'd100;

  localparam logic [15:0] DEFAULT_US = 16'd1500;
  localparam logic [16:0] AGE_MAX    = 17'h10000;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
    logic advance;
  } ppmfd_cmd_t;

  typedef struct packed {
    logic last;
  } ppmfd_sts_t;

endpackage

`default_nettype wire

// ===== hdl/ppmfd_ctrl.sv =====
// Sequencing controller for the PPM frame decoder: accept, execute, load
// result, present result. Uses ppmfd_pkg command/status types.
`default_nettype none

module ppmfd_ctrl import ppmfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire ppmfd_sts_t sts_i,
  output ppmfd_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.load    = (state_q == S_LOAD);
    cmd_o.advance = out_valid_o && out_ready_i && !sts_i.last;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_LOAD;
      S_LOAD: state_d = S_OUT;
      S_OUT: begin
        // walk on to the next channel of a frame read, else go back for input
        if (out_ready_i) state_d = sts_i.last ? S_IDLE : S_LOAD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ppmfd_datapath.sv =====
// Datapath of the PPM frame decoder: configuration registers, interval
// check, ping-pong channel store, frame age and result register.
// Uses ppmfd_pkg; driven by ppmfd_ctrl.
`default_nettype none

module ppmfd_datapath import ppmfd_pkg::*; #(
  parameter int unsigned CHANNEL_SLOTS = CHANNEL_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ppmfd_cmd_t  cmd_i,
  output ppmfd_sts_t       sts_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] edge_time_us_i,
  input  wire logic [7:0]  channel_index_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             ok_o,
  output logic [2:0]       edge_status_o,
  output logic [3:0]       channel_slot_o,
  output logic [15:0]      channel_value_o,
  output logic [4:0]       channel_count_o,
  output logic             online_o,
  output logic             last_o
);

  localparam int unsigned SlotW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(CHANNEL_SLOTS + 1);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(CHANNEL_SLOTS);

  // configuration
  logic        enable_q, enable_d;
  logic [15:0] sync_gap_q, sync_gap_d;
  logic [15:0] pulse_min_q, pulse_min_d;
  logic [15:0] pulse_max_q, pulse_max_d;
  logic [4:0]  min_ch_q, min_ch_d;
  logic [15:0] timeout_q, timeout_d;

  // decoder state
  logic [31:0]     last_edge_q, last_edge_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] pub_count_q, pub_count_d;
  logic            held_q, held_d;
  logic [16:0]     age_q, age_d;
  logic            pub_bank_q, pub_bank_d;

  // two banks: one fills while the other is published; publish swaps them
  logic [15:0] store_q [2][CHANNEL_SLOTS];
  logic        wr_en;

  // captured word and execution results
  logic [1:0]      op_q, op_d;
  logic [7:0]      idx_q, idx_d;
  logic [31:0]     pulse_q, pulse_d;
  logic [2:0]      st_q, st_d;
  logic [3:0]      eslot_q, eslot_d;
  logic [15:0]     eval_q, eval_d;
  logic [CntW-1:0] walk_q, walk_d;

  // result register
  logic        ok_q, ok_d;
  logic [2:0]  est_q, est_d;
  logic [3:0]  slot_q, slot_d;
  logic [15:0] val_q, val_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        onl_q, onl_d;
  logic        last_q, last_d;

  logic            in_gap, width_ok, enough, room, online;
  logic [SlotW-1:0] rd_addr;
  logic [15:0]     rd_data;
  logic [CntW-1:0] walk_nxt;

  assign in_gap   = (pulse_q >= {16'd0, sync_gap_q});
  assign width_ok = (pulse_q[31:16] == 16'd0) && (pulse_q[15:0] >= pulse_min_q) &&
                    (pulse_q[15:0] <= pulse_max_q);
  assign enough   = (5'(fill_q) >= min_ch_q);
  assign room     = (fill_q < SlotsCnt);
  assign online   = enable_q && held_q && (age_q <= {1'b0, timeout_q});
  assign walk_nxt = walk_q + CntW'(1);
  assign rd_addr  = (op_q == OP_READ_ONE) ? idx_q[SlotW-1:0] : walk_q[SlotW-1:0];
  assign rd_data  = store_q[pub_bank_q][rd_addr];

  always_comb begin
    enable_d    = enable_q;
    sync_gap_d  = sync_gap_q;
    pulse_min_d = pulse_min_q;
    pulse_max_d = pulse_max_q;
    min_ch_d    = min_ch_q;
    timeout_d   = timeout_q;
    last_edge_d = last_edge_q;
    fill_d      = fill_q;
    pub_count_d = pub_count_q;
    held_d      = held_q;
    age_d       = age_q;
    pub_bank_d  = pub_bank_q;
    op_d        = op_q;
    idx_d       = idx_q;
    pulse_d     = pulse_q;
    st_d        = st_q;
    eslot_d     = eslot_q;
    eval_d      = eval_q;
    walk_d      = walk_q;
    wr_en       = 1'b0;

    if (cmd_i.capture) begin
      op_d    = operation_i;
      idx_d   = channel_index_i;
      pulse_d = edge_time_us_i - last_edge_q;
      walk_d  = '0;
      if (operation_i == OP_EDGE && enable_q) last_edge_d = edge_time_us_i;
    end

    if (cmd_i.exec) begin
      st_d    = ST_IGNORED;
      eslot_d = 4'd0;
      eval_d  = 16'd0;
      case (op_q)
        OP_EDGE: begin
          if (enable_q) begin
            if (in_gap) begin
              if (enough) begin
                pub_bank_d  = ~pub_bank_q;
                pub_count_d = fill_q;
                held_d      = 1'b1;
                age_d       = '0;
                st_d        = ST_PUBLISHED;
              end else begin
                st_d = ST_SHORT;
              end
              fill_d = '0;
            end else if (width_ok) begin
              if (room) begin
                wr_en   = 1'b1;
                eslot_d = 4'(fill_q);
                eval_d  = pulse_q[15:0];
                fill_d  = fill_q + CntW'(1);
                st_d    = ST_STORED;
              end else begin
                fill_d = '0;
                st_d   = ST_OVERFLOW;
              end
            end else begin
              fill_d = '0;
              st_d   = ST_BAD_WIDTH;
            end
          end
        end
        OP_TICK: begin
          if (age_q != AGE_MAX) age_d = age_q + 17'd1;
        end
        default: ;
      endcase
    end

    if (cmd_i.advance) walk_d = walk_nxt;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLE: begin
          if (cfg_data_i[0]) begin
            if (!enable_q) begin
              fill_d      = '0;
              pub_count_d = '0;
              held_d      = 1'b0;
              age_d       = '0;
            end
            enable_d = 1'b1;
          end else begin
            enable_d = 1'b0;
            held_d   = 1'b0;
            fill_d   = '0;
          end
        end
        REG_SYNC_GAP:     sync_gap_d  = cfg_data_i;
        REG_PULSE_MIN:    pulse_min_d = cfg_data_i;
        REG_PULSE_MAX:    pulse_max_d = cfg_data_i;
        REG_MIN_CHANNELS: min_ch_d    = cfg_data_i[4:0];
        REG_TIMEOUT:      timeout_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  // result word for the current item or frame position
  always_comb begin
    ok_d   = ok_q;
    est_d  = est_q;
    slot_d = slot_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    onl_d  = onl_q;
    last_d = last_q;
    if (cmd_i.load) begin
      ok_d   = 1'b1;
      est_d  = ST_IGNORED;
      slot_d = 4'd0;
      val_d  = 16'd0;
      cnt_d  = 5'(pub_count_q);
      onl_d  = online;
      last_d = 1'b1;
      case (op_q)
        OP_EDGE, OP_TICK: begin
          est_d  = st_q;
          slot_d = eslot_q;
          val_d  = eval_q;
        end
        OP_READ_ONE: begin
          if (!online) begin
            ok_d  = 1'b0;
            cnt_d = 5'd0;
          end else begin
            slot_d = idx_q[3:0];
            val_d  = (idx_q < 8'(pub_count_q)) ? rd_data : DEFAULT_US;
          end
        end
        default: begin
          if (!online) begin
            ok_d  = 1'b0;
            cnt_d = 5'd0;
          end else if (pub_count_q != '0) begin
            slot_d = 4'(walk_q);
            val_d  = rd_data;
            last_d = (walk_nxt == pub_count_q);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      sync_gap_q  <= SYNC_GAP_RST;
      pulse_min_q <= PULSE_MIN_RST;
      pulse_max_q <= PULSE_MAX_RST;
      min_ch_q    <= MIN_CHANNELS_RST;
      timeout_q   <= TIMEOUT_RST;
      last_edge_q <= '0;
      fill_q      <= '0;
      pub_count_q <= '0;
      held_q      <= 1'b0;
      age_q       <= '0;
      pub_bank_q  <= 1'b0;
      op_q        <= OP_EDGE;
      walk_q      <= '0;
      last_q      <= 1'b1;
    end else begin
      enable_q    <= enable_d;
      sync_gap_q  <= sync_gap_d;
      pulse_min_q <= pulse_min_d;
      pulse_max_q <= pulse_max_d;
      min_ch_q    <= min_ch_d;
      timeout_q   <= timeout_d;
      last_edge_q <= last_edge_d;
      fill_q      <= fill_d;
      pub_count_q <= pub_count_d;
      held_q      <= held_d;
      age_q       <= age_d;
      pub_bank_q  <= pub_bank_d;
      op_q        <= op_d;
      walk_q      <= walk_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pulse_q <= pulse_d;
    st_q    <= st_d;
    eslot_q <= eslot_d;
    eval_q  <= eval_d;
    ok_q    <= ok_d;
    est_q   <= est_d;
    slot_q  <= slot_d;
    val_q   <= val_d;
    cnt_q   <= cnt_d;
    onl_q   <= onl_d;
    if (wr_en) store_q[~pub_bank_q][fill_q[SlotW-1:0]] <= pulse_q[15:0];
  end

  assign sts_o.last      = last_q;
  assign ok_o            = ok_q;
  assign edge_status_o   = est_q;
  assign channel_slot_o  = slot_q;
  assign channel_value_o = val_q;
  assign channel_count_o = cnt_q;
  assign online_o        = onl_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

// ===== hdl/ppm_frame_decoder.sv =====
// Top level of the PPM frame decoder: controller plus datapath.
// Depends on ppmfd_pkg, ppmfd_ctrl and ppmfd_datapath.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o | operation_i, edge_time_us_i, channel_index_i
//  out     | out_valid_o/out_ready_i | ok_o, edge_status_o, channel_slot_o,
//          |                         | channel_value_o, channel_count_o, online_o,
//          |                         | last_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item passes through accept, execute, load and present with a ready sink.
// A whole-frame read gives one word per stored channel, each through a load
// and a present step of the controller's load/present loop over the single
// store read port. One item is in work at a time; in_ready_o is low until the
// last word is taken. A stalled out_ready_i holds the result word.
// Reset is immediate: channel stores are not cleared and never read unwritten.
`default_nettype none

module ppm_frame_decoder import ppmfd_pkg::*; #(
  parameter int unsigned CHANNEL_SLOTS = CHANNEL_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] edge_time_us_i,
  input  wire logic [7:0]  channel_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic [2:0]       edge_status_o,
  output logic [3:0]       channel_slot_o,
  output logic [15:0]      channel_value_o,
  output logic [4:0]       channel_count_o,
  output logic             online_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  ppmfd_cmd_t cmd;
  ppmfd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ppmfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppmfd_datapath #(
    .CHANNEL_SLOTS (CHANNEL_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .edge_time_us_i  (edge_time_us_i),
    .channel_index_i (channel_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .ok_o            (ok_o),
    .edge_status_o   (edge_status_o),
    .channel_slot_o  (channel_slot_o),
    .channel_value_o (channel_value_o),
    .channel_count_o (channel_count_o),
    .online_o        (online_o),
    .last_o          (last_o)
  );

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result word is pending");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##3 out_valid_o)
    else $error("result word not presented three cycles after accept");

  a_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (ok_o && edge_status_o == ST_IGNORED))
    else $error("non-final word outside a successful frame read");
`endif

endmodule

`default_nettype wire

// ===== tb/ppm_frame_decoder_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ppm_frame_decoder: directed and random PPM edge,
// tick and read traffic, checked against an in-bench frame decoder model.
// Depends on ppmfd_pkg and the ppm_frame_decoder RTL.

module ppm_frame_decoder_tb;
  import ppmfd_pkg::*;

  localparam int SLOTS       = CHANNEL_SLOTS_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] value;
    logic [4:0]  count;
    logic        online;
    logic        last;
  } ppm_word_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i     = OP_EDGE;
  logic [31:0] edge_time_us_i  = '0;
  logic [7:0]  channel_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        ok_o;
  logic [2:0]  edge_status_o;
  logic [3:0]  channel_slot_o;
  logic [15:0] channel_value_o;
  logic [4:0]  channel_count_o;
  logic        online_o;
  logic        last_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i     = REG_ENABLE;
  logic [15:0] cfg_data_i      = '0;

  ppm_frame_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .edge_time_us_i  (edge_time_us_i),
    .channel_index_i (channel_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ok_o            (ok_o),
    .edge_status_o   (edge_status_o),
    .channel_slot_o  (channel_slot_o),
    .channel_value_o (channel_value_o),
    .channel_count_o (channel_count_o),
    .online_o        (online_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int send_gap_pct = 37;
  int recv_gap_pct = 62;
  int stall_left   = 0;
  int fail_count   = 0;
  int quiet_cycles = 0;

  // Decoder model state and register copies
  logic        cfg_enable       = 1'b0;
  logic [15:0] cfg_sync_gap     = SYNC_GAP_RST;
  logic [15:0] cfg_pulse_min    = PULSE_MIN_RST;
  logic [15:0] cfg_pulse_max    = PULSE_MAX_RST;
  logic [4:0]  cfg_min_channels = MIN_CHANNELS_RST;
  logic [15:0] cfg_timeout      = TIMEOUT_RST;
  logic [31:0] last_edge_us     = '0;
  logic [3:0]  fill_idx         = '0;
  logic [15:0] fill_chan [SLOTS];
  logic [15:0] held_chan [SLOTS];
  logic [3:0]  held_count       = '0;
  logic        frame_held       = 1'b0;
  logic [16:0] age_ms           = '0;

  ppm_word_t expected_words [$];
  ppm_word_t seen_word;
  ppm_word_t want_word;

  function automatic logic frame_online();
    return cfg_enable && frame_held && (age_ms <= {1'b0, cfg_timeout});
  endfunction

  function automatic void push_word(input logic ok, input logic [2:0] status,
                                    input logic [3:0] slot, input logic [15:0] value,
                                    input logic [4:0] count, input logic last);
    ppm_word_t w;
    w = '{ok, status, slot, value, count, frame_online(), last};
    expected_words.push_back(w);
  endfunction

  function automatic string word_text(input ppm_word_t w);
    return $sformatf("ok=%0d st=%0d slot=%0d val=%0d cnt=%0d online=%0d last=%0d",
                     w.ok, w.status, w.slot, w.value, w.count, w.online, w.last);
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < MAX_REPORTS) $display("%t %s", $realtime, msg);
    fail_count++;
  endfunction

  task automatic apply_register(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_ENABLE: begin
        if (data[0]) begin
          if (!cfg_enable) begin
            fill_idx   = '0;
            held_count = '0;
            frame_held = 1'b0;
            age_ms     = '0;
          end
          cfg_enable = 1'b1;
        end else begin
          cfg_enable = 1'b0;
          frame_held = 1'b0;
          fill_idx   = '0;
        end
      end
      REG_SYNC_GAP:     cfg_sync_gap     = data;
      REG_PULSE_MIN:    cfg_pulse_min    = data;
      REG_PULSE_MAX:    cfg_pulse_max    = data;
      REG_MIN_CHANNELS: cfg_min_channels = data[4:0];
      REG_TIMEOUT:      cfg_timeout      = data;
      default: ;
    endcase
  endtask

  // Work out the result words of one accepted item and queue them
  task automatic decode_item(input logic [1:0] op, input logic [31:0] stamp,
                             input logic [7:0] idx);
    logic [31:0] pulse;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] width;
    logic [4:0]  count;
    slot  = '0;
    width = '0;
    count = {1'b0, held_count};
    if (op == OP_EDGE) begin
      if (!cfg_enable) begin
        push_word(1'b1, ST_IGNORED, '0, '0, count, 1'b1);
      end else begin
        pulse = stamp - last_edge_us;
        last_edge_us = stamp;
        if (pulse >= {16'd0, cfg_sync_gap}) begin
          if ({1'b0, fill_idx} >= cfg_min_channels) begin
            for (int i = 0; i < SLOTS; i++)
              if (i < fill_idx) held_chan[i] = fill_chan[i];
            held_count = fill_idx;
            frame_held = 1'b1;
            age_ms     = '0;
            status     = ST_PUBLISHED;
          end else begin
            status = ST_SHORT;
          end
          fill_idx = '0;
        end else if (pulse >= {16'd0, cfg_pulse_min} && pulse <= {16'd0, cfg_pulse_max}) begin
          if (fill_idx < SLOTS) begin
            fill_chan[fill_idx[2:0]] = pulse[15:0];
            slot     = fill_idx;
            width    = pulse[15:0];
            fill_idx = fill_idx + 4'd1;
            status   = ST_STORED;
          end else begin
            fill_idx = '0;
            status   = ST_OVERFLOW;
          end
        end else begin
          fill_idx = '0;
          status   = ST_BAD_WIDTH;
        end
        push_word(1'b1, status, slot, width, {1'b0, held_count}, 1'b1);
      end
    end else if (op == OP_TICK) begin
      if (age_ms < AGE_MAX) age_ms = age_ms + 17'd1;
      push_word(1'b1, ST_IGNORED, '0, '0, count, 1'b1);
    end else if (!frame_online()) begin
      push_word(1'b0, ST_IGNORED, '0, '0, '0, 1'b1);
    end else if (op == OP_READ_ONE) begin
      width = DEFAULT_US;
      if (idx < held_count && idx < SLOTS) width = held_chan[idx[2:0]];
      push_word(1'b1, ST_IGNORED, idx[3:0], width, count, 1'b1);
    end else if (held_count == 0) begin
      push_word(1'b1, ST_IGNORED, '0, '0, '0, 1'b1);
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (i < held_count)
          push_word(1'b1, ST_IGNORED, 4'(i), held_chan[i], count,
                    (i + 1 == held_count) || (i + 1 == SLOTS));
    end
  endtask

  // Receiver: random stalls, or a long hold-off while stall_left runs down
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_word = '{ok_o, edge_status_o, channel_slot_o, channel_value_o,
                    channel_count_o, online_o, last_o};
      if (expected_words.size() == 0) begin
        note_failure({"unexpected word: ", word_text(seen_word)});
      end else begin
        want_word = expected_words.pop_front();
        if (seen_word !== want_word)
          note_failure({"mismatch: expected ", word_text(want_word),
                        " got ", word_text(seen_word)});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL ppm_frame_decoder");
      $finish;
    end
  end

  // All driver tasks are entered and left just after a falling edge
  task automatic send_item(input logic [1:0] op, input logic [31:0] stamp,
                           input logic [7:0] idx);
    while ($urandom_range(99) < send_gap_pct) @(negedge clk_i);
    in_valid_i      = 1'b1;
    operation_i     = op;
    edge_time_us_i  = stamp;
    channel_index_i = idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_item(op, stamp, idx);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_op(input logic [1:0] op);
    send_item(op, $urandom, 8'($urandom_range(255)));
  endtask

  task automatic send_edge_after(input logic [31:0] gap);
    send_item(OP_EDGE, last_edge_us + gap, 8'($urandom_range(255)));
  endtask

  task automatic wait_for_results();
    while (expected_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
    wait_for_results();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_timing(input logic [4:0] min_ch, input logic [15:0] timeout);
    write_register(REG_SYNC_GAP, SYNC_GAP_RST);
    write_register(REG_PULSE_MIN, PULSE_MIN_RST);
    write_register(REG_PULSE_MAX, PULSE_MAX_RST);
    write_register(REG_MIN_CHANNELS, {11'd0, min_ch});
    write_register(REG_TIMEOUT, timeout);
  endtask

  function automatic logic [31:0] channel_gap();
    int lo;
    int hi;
    lo = cfg_pulse_min;
    hi = cfg_pulse_max;
    if (hi >= int'(cfg_sync_gap)) hi = int'(cfg_sync_gap) - 1;
    if (lo > hi) return $urandom_range(65535);
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [31:0] bad_gap();
    if ($urandom_range(1)) return {16'd0, cfg_pulse_max} + 32'd1;
    return {16'd0, cfg_pulse_min} - 32'd1;
  endfunction

  function automatic logic [31:0] sync_gap_draw();
    if ($urandom_range(9) == 0) return $urandom;
    return {16'd0, cfg_sync_gap} + $urandom_range(2000);
  endfunction

  task automatic shuffle_registers();
    logic [15:0] data;
    data = 16'($urandom);
    data[0] = 1'b1;
    write_register(REG_ENABLE, data);
    write_register(REG_SYNC_GAP, 16'($urandom_range(4000, 2500)));
    write_register(REG_PULSE_MIN, 16'($urandom_range(1000, 700)));
    write_register(REG_PULSE_MAX, 16'($urandom_range(2300, 1800)));
    data = 16'($urandom);
    data[4:0] = 5'($urandom_range(9, 1));
    write_register(REG_MIN_CHANNELS, data);
    write_register(REG_TIMEOUT, 16'($urandom_range(40, 3)));
  endtask

  task automatic test_disabled_block();
    send_item(OP_EDGE, 32'hFFFF_FFFF, 8'hFF);
    send_op(OP_TICK);
    send_item(OP_READ_ONE, $urandom, 8'd255);
    send_op(OP_READ_ALL);
  endtask

  task automatic test_directed_frame();
    write_register(REG_ENABLE, 16'h0001);
    send_item(OP_EDGE, 32'hFFFF_F000, 8'h00);   // huge gap from zero: short sync
    send_edge_after(32'd900);
    send_edge_after(32'd2100);
    send_edge_after(32'd1500);                   // timestamp wraps here
    send_edge_after(32'd1000);
    send_edge_after(32'd3000);                   // publish four channels
    send_op(OP_TICK);
    send_op(OP_READ_ALL);
    send_item(OP_READ_ONE, $urandom, 8'd3);
    send_item(OP_READ_ONE, $urandom, 8'd4);
    send_item(OP_READ_ONE, $urandom, 8'd255);
    send_edge_after(32'd899);
    send_edge_after(32'd2101);
    send_edge_after(32'd2999);
    send_item(OP_EDGE, 32'h0000_0000, 8'h55);
  endtask

  task automatic test_register_extremes();
    // Zero sync gap and zero channels: every edge publishes an empty frame
    write_register(REG_SYNC_GAP, 16'd0);
    write_register(REG_MIN_CHANNELS, 16'hFFE0);
    send_edge_after($urandom);
    send_op(OP_READ_ALL);
    send_item(OP_READ_ONE, $urandom, 8'd2);
    // Widest pulse window, unreachable channel minimum, then slot overflow
    write_register(REG_SYNC_GAP, 16'hFFFF);
    write_register(REG_PULSE_MIN, 16'd0);
    write_register(REG_PULSE_MAX, 16'hFFFF);
    write_register(REG_MIN_CHANNELS, 16'd16);
    send_edge_after(32'd0);
    send_edge_after(32'd65534);
    repeat (SLOTS - 1) send_edge_after($urandom_range(65534));
    send_edge_after(32'd65535);
    // Inverted window rejects everything short of a sync
    write_register(REG_PULSE_MIN, 16'd2000);
    write_register(REG_PULSE_MAX, 16'd1000);
    send_edge_after(32'd1500);
    // Zero timeout: online only until the first tick
    load_timing(5'd1, 16'd0);
    send_edge_after(32'd1500);
    send_edge_after(32'd3000);
    send_item(OP_READ_ONE, $urandom, 8'd0);
    send_op(OP_TICK);
    send_item(OP_READ_ONE, $urandom, 8'd0);
  endtask

  task automatic test_disable_clears();
    write_register(REG_TIMEOUT, TIMEOUT_RST);
    send_item(OP_READ_ONE, $urandom, 8'd0);
    write_register(REG_ENABLE, 16'h0000);
    send_item(OP_READ_ONE, $urandom, 8'd0);
    send_edge_after(32'd1500);
    write_register(REG_ENABLE, 16'hFFFF);
    send_op(OP_READ_ALL);
    send_edge_after(32'd5000);
    send_edge_after(32'd1500);
    send_edge_after(32'd3000);
    write_register(REG_ENABLE, 16'h0003);      // already running: keep the frame
    send_op(OP_READ_ALL);
  endtask

  task automatic test_backpressure();
    load_timing(5'd1, TIMEOUT_RST);
    send_edge_after(32'd5000);
    repeat (SLOTS) send_edge_after(channel_gap());
    send_edge_after(32'd4000);
    stall_left = 300;
    repeat (4) send_op(OP_READ_ALL);
    send_item(OP_READ_ONE, $urandom, 8'd7);
    wait_for_results();
    repeat (2) send_op(OP_READ_ALL);
  endtask

  task automatic random_traffic(input int n_items);
    int sent;
    int pick;
    int chans;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_edge_after(sync_gap_draw());
        sent++;
        chans = $urandom_range(SLOTS + 1);
        for (int c = 0; c < chans; c++) begin
          if ($urandom_range(99) < 6) send_edge_after(bad_gap());
          else send_edge_after(channel_gap());
          sent++;
          if ($urandom_range(99) < 12) begin
            send_op(2'($urandom_range(3, 1)));
            sent++;
          end
        end
      end else begin
        if (pick < 70) send_op(OP_TICK);
        else if (pick < 80)
          send_item(OP_READ_ONE, $urandom,
                    ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                                               8'($urandom_range(9)));
        else if (pick < 90) send_op(OP_READ_ALL);
        else if (pick < 95) send_item(OP_EDGE, $urandom, 8'($urandom_range(255)));
        else send_edge_after($urandom);
        sent++;
      end
    end
  endtask

  // Age the frame up to the timeout, then one tick past it drops it offline
  task automatic test_frame_timeout();
    write_register(REG_ENABLE, 16'h0000);
    write_register(REG_ENABLE, 16'h0001);
    load_timing(5'd1, 16'd12);
    send_edge_after(32'd5000);
    send_edge_after(32'd1234);
    send_edge_after(32'd4000);
    repeat (12) send_op(OP_TICK);
    send_item(OP_READ_ONE, $urandom, 8'd0);
    send_op(OP_TICK);
    send_item(OP_READ_ONE, $urandom, 8'd0);
    repeat (3) send_op(OP_TICK);
    send_op(OP_READ_ALL);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_disabled_block();
    test_directed_frame();
    test_register_extremes();
    test_disable_clears();
    shuffle_registers();
    random_traffic(55);

    send_gap_pct = 62;
    recv_gap_pct = 37;
    test_backpressure();
    shuffle_registers();
    random_traffic(55);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    shuffle_registers();
    random_traffic(55);
    test_frame_timeout();

    wait_for_results();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0)
      $display("PASS ppm_frame_decoder");
    else
      $display("FAIL ppm_frame_decoder");
    $finish;
  end

endmodule
